/* rtl/mjm_pkg.sv */
package mjm_pkg;

  localparam int AXIS_W   = 16;
  localparam int CODE_W   = 12;
  localparam int STRAFE_W = 9;
  localparam int NLANE    = 4;

  // tan(22.5 deg) in units of 1/65536
  localparam logic [AXIS_W-1:0] TAN_NUM = 16'd27146;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [STRAFE_W-1:0]      strafe_t;
  typedef logic [CODE_W-1:0]        code_t;
  typedef logic signed [1:0]        sgn_t;

  localparam strafe_t STRAFE_RST = 9'd128;
  localparam sgn_t    SGN_POS    = 2'sb01;
  localparam sgn_t    SGN_NEG    = 2'sb11;
  localparam sgn_t    SGN_ZERO   = 2'sb00;

  // bits needed for the magnitude of a mixed wheel power
  function automatic int mag_width(input int frac);
    int a;
    int b;
    begin
      a = frac + 1;
      b = 30 - frac;
      return ((a > b) ? a : b) + 2;
    end
  endfunction

endpackage

/* rtl/mjm_if.sv */
interface mjm_in_if import mjm_pkg::*; ();
  logic  valid;
  logic  ready;
  axis_t x_in;
  axis_t y_in;
  axis_t turn_in;

  modport source(output valid, x_in, y_in, turn_in, input ready);
  modport sink(input valid, x_in, y_in, turn_in, output ready);
endinterface

interface mjm_out_if import mjm_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t code_a;
  logic  dir_a;
  code_t code_b;
  logic  dir_b;
  code_t code_c;
  logic  dir_c;
  code_t code_d;
  logic  dir_d;

  modport source(output valid, code_a, dir_a, code_b, dir_b, code_c, dir_c, code_d, dir_d,
                 input ready);
  modport sink(input valid, code_a, dir_a, code_b, dir_b, code_c, dir_c, code_d, dir_d,
               output ready);
endinterface

/* rtl/mjm_mix.sv */
module mjm_mix import mjm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  axis_t                                       x_in,
  input  axis_t                                       y_in,
  input  axis_t                                       turn_in,
  input  strafe_t                                     strafe,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [NLANE-1:0][mag_width(FRAC_BITS):0]    p
);

  localparam int MAGW = mag_width(FRAC_BITS);
  localparam int PW   = MAGW + 1;
  localparam int TTW  = 31 - FRAC_BITS;
  localparam int SQW  = 2 * AXIS_W - 1;

  function automatic sgn_t sign_of(input axis_t v);
    begin
      if (v > 0) return SGN_POS;
      else if (v < 0) return SGN_NEG;
      else return SGN_ZERO;
    end
  endfunction

  // stage 1: direction snap and turn square
  logic                     v1_r;
  sgn_t                     sx_r, sx_nxt;
  sgn_t                     sy_r, sy_nxt;
  sgn_t                     ts_r;
  logic [TTW-1:0]           ttm_r, ttm_nxt;
  logic                     rdy1, rdy2;

  logic [AXIS_W-1:0]        ax, ay;
  logic [2*AXIS_W-1:0]      lhs_h, rhs_h, lhs_v, rhs_v;
  logic                     horiz, vert;
  logic signed [2*AXIS_W-1:0] sq;
  logic [SQW-1:0]           sqm;

  assign ax    = x_in[AXIS_W-1] ? AXIS_W'(~x_in + 1'b1) : AXIS_W'(x_in);
  assign ay    = y_in[AXIS_W-1] ? AXIS_W'(~y_in + 1'b1) : AXIS_W'(y_in);
  assign lhs_h = {ay, {AXIS_W{1'b0}}};
  assign rhs_h = (2*AXIS_W)'(ax) * (2*AXIS_W)'(TAN_NUM);
  assign lhs_v = {ax, {AXIS_W{1'b0}}};
  assign rhs_v = (2*AXIS_W)'(ay) * (2*AXIS_W)'(TAN_NUM);
  assign horiz = lhs_h < rhs_h;
  assign vert  = lhs_v < rhs_v;
  assign sq    = (2*AXIS_W)'(turn_in) * (2*AXIS_W)'(turn_in);
  assign sqm   = sq[SQW-1:0];

  // centre falls through to diagonal with both signs zero
  always_comb begin
    sx_nxt  = vert  ? SGN_ZERO : sign_of(x_in);
    sy_nxt  = horiz ? SGN_ZERO : sign_of(y_in);
    ttm_nxt = sqm[SQW-1:FRAC_BITS];
  end

  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      ts_r  <= sign_of(turn_in);
      ttm_r <= ttm_nxt;
    end
  end

  // stage 2: wheel mix
  logic                       v2_r;
  logic [NLANE-1:0][PW-1:0]   p_r, p_nxt;
  logic signed [PW-1:0]       txm, tx, ty, tt, ttm_s, one_s;

  assign txm   = $signed(PW'(strafe) << (FRAC_BITS - 8));
  assign one_s = $signed(PW'(1) << FRAC_BITS);
  assign ttm_s = $signed(PW'(ttm_r));

  always_comb begin
    case (sx_r)
      SGN_POS: tx = txm;
      SGN_NEG: tx = -txm;
      default: tx = '0;
    endcase
    case (sy_r)
      SGN_POS: ty = one_s;
      SGN_NEG: ty = -one_s;
      default: ty = '0;
    endcase
    case (ts_r)
      SGN_POS: tt = ttm_s;
      SGN_NEG: tt = -ttm_s;
      default: tt = '0;
    endcase
    p_nxt[0] = ty + tx + tt;
    p_nxt[1] = ty - tx - tt;
    p_nxt[2] = ty - tx + tt;
    p_nxt[3] = ty + tx - tt;
  end

  assign rdy2 = !v2_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      p_r <= p_nxt;
    end
  end

  assign out_valid = v2_r;
  assign p         = p_r;

endmodule

/* rtl/mjm_scale.sv */
module mjm_scale import mjm_pkg::*; #(
  parameter int FRAC_BITS      = 14,
  parameter int DAC_FULL_SCALE = 4095
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [NLANE-1:0][mag_width(FRAC_BITS):0] p,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [NLANE-1:0][mag_width(FRAC_BITS)+$clog2(DAC_FULL_SCALE+1)-1:0] num,
  output logic [mag_width(FRAC_BITS)-1:0]        den,
  output logic [NLANE-1:0]                       dir
);

  localparam int MAGW = mag_width(FRAC_BITS);
  localparam int PW   = MAGW + 1;
  localparam int QW   = $clog2(DAC_FULL_SCALE + 1);
  localparam int NW   = MAGW + QW;

  logic                       v_r;
  logic                       rdy;
  logic [NLANE-1:0][MAGW-1:0] mg;
  logic [MAGW-1:0]            m01, m23, m, one_u, den_nxt;
  logic [NLANE-1:0][NW-1:0]   num_r, num_nxt;
  logic [MAGW-1:0]            den_r;
  logic [NLANE-1:0]           dir_r, dir_nxt;
  logic [NLANE-1:0]           neg, nz;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      neg[i]     = p[i][PW-1];
      nz[i]      = |p[i];
      mg[i]      = neg[i] ? MAGW'(-$signed(p[i])) : MAGW'(p[i]);
      num_nxt[i] = NW'(mg[i]) * NW'(DAC_FULL_SCALE);
    end
    // right-hand wheels run from the negated power
    dir_nxt[0] = neg[0];
    dir_nxt[1] = !neg[1] && nz[1];
    dir_nxt[2] = neg[2];
    dir_nxt[3] = !neg[3] && nz[3];
  end

  assign m01     = (mg[0] > mg[1]) ? mg[0] : mg[1];
  assign m23     = (mg[2] > mg[3]) ? mg[2] : mg[3];
  assign m       = (m01 > m23) ? m01 : m23;
  assign one_u   = MAGW'(1) << FRAC_BITS;
  assign den_nxt = (m > one_u) ? m : one_u;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      dir_r <= dir_nxt;
    end
  end

  assign out_valid = v_r;
  assign num       = num_r;
  assign den       = den_r;
  assign dir       = dir_r;

endmodule

/* rtl/mjm_div_step.sv */
module mjm_div_step import mjm_pkg::*; #(
  parameter int NUM_W   = 30,
  parameter int DEN_W   = 18,
  parameter int Q_W     = 12,
  parameter int BIT_POS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [NLANE-1:0][NUM_W-1:0] rem_in,
  input  logic [NLANE-1:0][Q_W-1:0]   q_in,
  input  logic [DEN_W-1:0]            den_in,
  input  logic [NLANE-1:0]            dir_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [NLANE-1:0][NUM_W-1:0] rem_out,
  output logic [NLANE-1:0][Q_W-1:0]   q_out,
  output logic [DEN_W-1:0]            den_out,
  output logic [NLANE-1:0]            dir_out
);

  logic                        v_r;
  logic                        rdy;
  logic [NUM_W-1:0]            dsh;
  logic [NLANE-1:0][NUM_W-1:0] rem_r, rem_nxt;
  logic [NLANE-1:0][Q_W-1:0]   q_r, q_nxt;
  logic [DEN_W-1:0]            den_r;
  logic [NLANE-1:0]            dir_r;

  assign dsh = NUM_W'(den_in) << BIT_POS;

  // one restoring step per lane
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (rem_in[i] >= dsh) begin
        rem_nxt[i] = rem_in[i] - dsh;
        q_nxt[i]   = q_in[i] | (Q_W'(1) << BIT_POS);
      end else begin
        rem_nxt[i] = rem_in[i];
        q_nxt[i]   = q_in[i];
      end
    end
  end

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      den_r <= den_in;
      dir_r <= dir_in;
    end
  end

  assign out_valid = v_r;
  assign rem_out   = rem_r;
  assign q_out     = q_r;
  assign den_out   = den_r;
  assign dir_out   = dir_r;

endmodule

/* rtl/mecanum_joystick_motor_mixer.sv */
// channel | dir | beat contents
// --------+-----+-----------------------------------------------------------
// in_bus  | in  | x_in, y_in, turn_in (signed Q2.14)
// out_bus | out | code_a..code_d (12-bit DAC codes), dir_a..dir_d
// cfg     | in  | cfg_we, cfg_wdata: strafe scale (Q1.8), no read-back
//
// One beat per cycle while out_bus is ready. Stages in order: snap/square, mix,
// max/multiply, one divider stage per quotient bit, then the output register.
// Each stage has its own valid and can fill a bubble while later stages stall.
// Synchronous active-low reset clears the valid bits and sets the strafe scale
// to 128.
module mecanum_joystick_motor_mixer import mjm_pkg::*; #(
  parameter int DAC_FULL_SCALE = 4095,
  parameter int FRAC_BITS      = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  mjm_in_if.sink          in_bus,
  mjm_out_if.source       out_bus,
  input  logic            cfg_we,
  input  strafe_t         cfg_wdata
);

  localparam int MAGW = mag_width(FRAC_BITS);
  localparam int PW   = MAGW + 1;
  localparam int QW   = $clog2(DAC_FULL_SCALE + 1);
  localparam int NW   = MAGW + QW;
  localparam int EW   = (QW > CODE_W) ? QW : CODE_W;

  strafe_t strafe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strafe_r <= STRAFE_RST;
    end else if (cfg_we) begin
      strafe_r <= cfg_wdata;
    end
  end

  logic                     mix_v, mix_rdy;
  logic [NLANE-1:0][PW-1:0] mix_p;

  mjm_mix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .x_in     (in_bus.x_in),
    .y_in     (in_bus.y_in),
    .turn_in  (in_bus.turn_in),
    .strafe   (strafe_r),
    .out_valid(mix_v),
    .out_ready(mix_rdy),
    .p        (mix_p)
  );

  logic [QW:0]                        dv, dr;
  logic [QW:0][NLANE-1:0][NW-1:0]     drem;
  logic [QW:0][NLANE-1:0][QW-1:0]     dq;
  logic [QW:0][MAGW-1:0]              dden;
  logic [QW:0][NLANE-1:0]             ddir;

  mjm_scale #(
    .FRAC_BITS     (FRAC_BITS),
    .DAC_FULL_SCALE(DAC_FULL_SCALE)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mix_v),
    .in_ready (mix_rdy),
    .p        (mix_p),
    .out_valid(dv[0]),
    .out_ready(dr[0]),
    .num      (drem[0]),
    .den      (dden[0]),
    .dir      (ddir[0])
  );

  assign dq[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    mjm_div_step #(
      .NUM_W  (NW),
      .DEN_W  (MAGW),
      .Q_W    (QW),
      .BIT_POS(QW - 1 - k)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv[k]),
      .in_ready (dr[k]),
      .rem_in   (drem[k]),
      .q_in     (dq[k]),
      .den_in   (dden[k]),
      .dir_in   (ddir[k]),
      .out_valid(dv[k+1]),
      .out_ready(dr[k+1]),
      .rem_out  (drem[k+1]),
      .q_out    (dq[k+1]),
      .den_out  (dden[k+1]),
      .dir_out  (ddir[k+1])
    );
  end

  // output register: clamp to full scale, keep the low 12 bits
  logic                       out_v_r;
  logic                       out_rdy;
  code_t [NLANE-1:0]          code_r, code_nxt;
  logic [NLANE-1:0]           dir_r;
  logic [NLANE-1:0][QW-1:0]   qc;
  logic [NLANE-1:0][EW-1:0]   qe;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qc[i]       = (dq[QW][i] > QW'(DAC_FULL_SCALE)) ? QW'(DAC_FULL_SCALE) : dq[QW][i];
      qe[i]       = EW'(qc[i]);
      code_nxt[i] = qe[i][CODE_W-1:0];
    end
  end

  assign out_rdy = !out_v_r || out_bus.ready;
  assign dr[QW]  = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (dv[QW] && out_rdy) begin
      code_r <= code_nxt;
      dir_r  <= ddir[QW];
    end
  end

  assign out_bus.valid  = out_v_r;
  assign out_bus.code_a = code_r[0];
  assign out_bus.dir_a  = dir_r[0];
  assign out_bus.code_b = code_r[1];
  assign out_bus.dir_b  = dir_r[1];
  assign out_bus.code_c = code_r[2];
  assign out_bus.dir_c  = dir_r[2];
  assign out_bus.code_d = code_r[3];
  assign out_bus.dir_d  = dir_r[3];

endmodule
